@@ hdl/tfrnc_pkg.sv @@
`timescale 1ns / 1ps

package tfrnc_pkg;

  localparam int unsigned IndexW   = 10;
  localparam int unsigned PosW     = 16;
  localparam int unsigned TotalW   = 10;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned RadiusW  = 32;
  localparam int unsigned ActiveW  = 11;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CfgIdxW-1:0] REG_RADIUS_SQ    = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_ACTIVE_COUNT = 1'b1;

  localparam logic [RadiusW-1:0] RADIUS_SQ_RST    = 32'd429497;
  localparam logic [ActiveW-1:0] ACTIVE_COUNT_RST = 11'd100;
  localparam logic [TotalW-1:0]  TOTAL_MAX        = 10'd1023;

  typedef struct packed {
    logic              command;
    logic [IndexW-1:0] agent_index;
    logic [PosW-1:0]   pos_x;
    logic [PosW-1:0]   pos_y;
  } tfrnc_item_t;

  typedef struct packed {
    logic [IndexW-1:0] query_index;
    logic [TotalW-1:0] neighbour_total;
  } tfrnc_result_t;

  // status of the distance pipeline toward the sequencer
  typedef struct packed {
    logic busy;
    logic hit_vld;
    logic hit;
  } tfrnc_dist_stat_t;

endpackage

@@ hdl/tfrnc_ram.sv @@
`timescale 1ns / 1ps

module tfrnc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/tfrnc_dist.sv @@
`timescale 1ns / 1ps

module tfrnc_dist #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              vld_i,
  input  logic [COORD_BITS-1:0]             a_x_i,
  input  logic [COORD_BITS-1:0]             a_y_i,
  input  logic [COORD_BITS-1:0]             b_x_i,
  input  logic [COORD_BITS-1:0]             b_y_i,
  input  logic [tfrnc_pkg::RadiusW-1:0]     radius_sq_i,
  output tfrnc_pkg::tfrnc_dist_stat_t       stat_o
);

  import tfrnc_pkg::*;

  localparam int unsigned SqW  = 2 * COORD_BITS;
  localparam int unsigned CmpW = (SqW > RadiusW) ? SqW : RadiusW;

  logic                  s1_vld_q, s2_vld_q, s3_vld_q;
  logic [COORD_BITS-1:0] dx, dy, gx_d, gy_d, gx_q, gy_q;
  logic [SqW-1:0]        sqx_q, sqy_q, sum;
  logic                  hit_d, hit_q;

  // wrapped difference, folded to the short way around the torus
  always_comb begin
    dx   = a_x_i - b_x_i;
    dy   = a_y_i - b_y_i;
    gx_d = dx[COORD_BITS-1] ? (~dx + 1'b1) : dx;
    gy_d = dy[COORD_BITS-1] ? (~dy + 1'b1) : dy;
  end

  assign sum   = sqx_q + sqy_q;
  assign hit_d = CmpW'(sum) < CmpW'(radius_sq_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    gx_q  <= gx_d;
    gy_q  <= gy_d;
    sqx_q <= SqW'(gx_q) * SqW'(gx_q);
    sqy_q <= SqW'(gy_q) * SqW'(gy_q);
    hit_q <= hit_d;
  end

  assign stat_o.busy    = s1_vld_q | s2_vld_q | s3_vld_q;
  assign stat_o.hit_vld = s3_vld_q;
  assign stat_o.hit     = hit_q;

endmodule

@@ hdl/torus_fixed_radius_neighbour_count_core.sv @@
`timescale 1ns / 1ps
// Write beat: stored at the accepting edge; busy never rises.
// Query beat: fetch the query's own position, then scan min(active_count, MAX_AGENTS) agents;
//   the single position RAM port reads one stored agent per cycle.
// One query at a time; busy is high from the cycle after an in-range start to the result.
// Reset clears the sequencer and loads radius_sq/active_count defaults; RAM keeps junk.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
module torus_fixed_radius_neighbour_count_core #(
  parameter int unsigned MAX_AGENTS = 1024,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  tfrnc_pkg::tfrnc_item_t          item_i,
  input  logic                            cfg_we_i,
  input  logic [tfrnc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tfrnc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output logic                            res_strobe_o,
  output tfrnc_pkg::tfrnc_result_t        result_o
);

  import tfrnc_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_AGENTS);
  localparam int unsigned CW   = $clog2(MAX_AGENTS + 1);
  localparam int unsigned LW   = (CW > ActiveW) ? CW : ActiveW;
  localparam int unsigned EntW = 2 * COORD_BITS;

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOAD  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [RadiusW-1:0]    radius_sq_q;
  logic [ActiveW-1:0]    active_count_q;
  logic [CW-1:0]         cnt_q, cnt_d, limit;
  logic [IndexW-1:0]     qidx_q, qidx_d;
  logic [COORD_BITS-1:0] qx_q, qy_q;
  logic [TotalW-1:0]     total_q, total_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [AW-1:0]         rd_idx_q, rd_idx_d;
  logic                  res_strobe_q, res_strobe_d;
  tfrnc_result_t         res_q, res_d;

  logic                  accept, in_range;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_addr;
  logic [EntW-1:0]       ram_wdata, ram_rdata;
  logic [COORD_BITS-1:0] ent_x, ent_y;
  logic                  self_hit;
  tfrnc_dist_stat_t      dstat;

  assign accept   = start && !busy;
  assign busy     = (state_q != ST_IDLE);
  assign in_range = 32'(item_i.agent_index) < 32'(MAX_AGENTS);

  // scan bound: active_count, saturated at the store depth
  assign limit = (LW'(active_count_q) > LW'(MAX_AGENTS)) ? CW'(MAX_AGENTS)
                                                         : CW'(active_count_q);

  assign ram_wdata = {COORD_BITS'(item_i.pos_x), COORD_BITS'(item_i.pos_y)};
  assign ent_x     = ram_rdata[EntW-1:COORD_BITS];
  assign ent_y     = ram_rdata[COORD_BITS-1:0];
  assign self_hit  = (rd_idx_q == AW'(qidx_q));

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_sq_q    <= RADIUS_SQ_RST;
      active_count_q <= ACTIVE_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIUS_SQ:    radius_sq_q    <= cfg_wdata_i;
        REG_ACTIVE_COUNT: active_count_q <= cfg_wdata_i[ActiveW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: one RAM read per cycle while scanning
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    qidx_d       = qidx_q;
    total_d      = total_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    res_strobe_d = 1'b0;
    res_d        = res_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_addr     = AW'(item_i.agent_index);

    // count a hit leaving the distance pipe, saturate the total
    if (dstat.hit_vld && dstat.hit && (total_q != TOTAL_MAX)) begin
      total_d = total_q + 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (item_i.command == CMD_WRITE) begin
            ram_we = in_range;
          end else if (in_range) begin
            // fetch the queried agent's own position
            ram_re  = 1'b1;
            qidx_d  = item_i.agent_index;
            cnt_d   = '0;
            total_d = '0;
            state_d = ST_LOAD;
          end else begin
            // unknown agent: answer zero at once
            res_strobe_d          = 1'b1;
            res_d.query_index     = item_i.agent_index;
            res_d.neighbour_total = '0;
          end
        end
      end
      ST_LOAD: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_q == limit) begin
          state_d = ST_DRAIN;
        end else begin
          ram_re   = 1'b1;
          ram_addr = cnt_q[AW-1:0];
          rd_vld_d = 1'b1;
          rd_idx_d = cnt_q[AW-1:0];
          cnt_d    = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // hold until the last entry has been counted
        if (!rd_vld_q && !dstat.busy) begin
          res_strobe_d          = 1'b1;
          res_d.query_index     = qidx_q;
          res_d.neighbour_total = total_q;
          state_d               = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rd_vld_q     <= 1'b0;
      res_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      rd_vld_q     <= rd_vld_d;
      res_strobe_q <= res_strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    qidx_q   <= qidx_d;
    total_q  <= total_d;
    rd_idx_q <= rd_idx_d;
    res_q    <= res_d;
    // latch the queried position as it comes out of the RAM
    if (state_q == ST_LOAD) begin
      qx_q <= ent_x;
      qy_q <= ent_y;
    end
  end

  tfrnc_ram #(
    .WIDTH (EntW),
    .DEPTH (MAX_AGENTS)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // drop the queried agent itself before it enters the distance pipe
  tfrnc_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (rd_vld_q && !self_hit),
    .a_x_i       (qx_q),
    .a_y_i       (qy_q),
    .b_x_i       (ent_x),
    .b_y_i       (ent_y),
    .radius_sq_i (radius_sq_q),
    .stat_o      (dstat)
  );

  assign res_strobe_o = res_strobe_q;
  assign result_o     = res_q;

endmodule
